// ----- sv/timed_supply_shutdown_controller_macros.svh -----
// Assertion macros shared by the supply shutdown controller RTL.
// Included by files that carry concurrent checks; clocked on clk, reset rst.
`ifndef TIMED_SUPPLY_SHUTDOWN_CONTROLLER_MACROS_SVH
`define TIMED_SUPPLY_SHUTDOWN_CONTROLLER_MACROS_SVH
`ifndef SYNTHESIS
// Check that holds outside of reset.
`define TSSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check that holds at every edge, reset included.
`define TSSC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TSSC_ASSERT(lbl, prop, msg)
`define TSSC_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ----- sv/tssc_pkg.sv -----
// Package for the timed supply shutdown controller: event codes, phase codes,
// register indexes, character constants and the item and result structs.
`timescale 1ns / 1ps

package tssc_pkg;

  // Event codes.
  localparam logic [2:0] OP_ADDR_MATCH = 3'd0;
  localparam logic [2:0] OP_RX_BYTE    = 3'd1;
  localparam logic [2:0] OP_STOP       = 3'd2;
  localparam logic [2:0] OP_TICK       = 3'd3;
  localparam logic [2:0] OP_WD_WAKE    = 3'd4;
  localparam logic [2:0] OP_PIN_WAKE   = 3'd5;

  // Supply phases.
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_WAIT = 2'd1;
  localparam logic [1:0] PH_OFF  = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_CLIENT_ADDRESS = 2'd0;
  localparam logic [1:0] CFG_WAIT_SECONDS   = 2'd1;
  localparam logic [1:0] CFG_FRAME_LENGTH   = 2'd2;

  localparam logic [6:0]  CLIENT_ADDRESS_RST = 7'd0;
  localparam logic [12:0] WAIT_SECONDS_RST   = 13'd30;
  localparam logic [4:0]  FRAME_LENGTH_RST   = 5'd8;

  // Seconds between watchdog wakes.
  localparam int unsigned WAKE_PERIOD_S = 8;

  localparam logic [7:0] CHAR_S = 8'h53;
  localparam logic [7:0] CHAR_0 = 8'h30;
  localparam logic [7:0] CHAR_9 = 8'h39;

  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  typedef struct packed {
    logic [2:0] opcode;
    logic [6:0] bus_address;
    logic       write_direction;
    logic [7:0] data_byte;
  } tssc_item_t;

  typedef struct packed {
    logic        regulator_on;
    logic [1:0]  phase;
    logic        frame_done;
    logic        command_valid;
    logic [15:0] off_duration;
  } tssc_result_t;

endpackage

// ----- sv/tssc_core.sv -----
// Event decoder and state registers of the supply shutdown controller.
// Holds the configuration registers; depends on tssc_pkg.
`timescale 1ns / 1ps

module tssc_core
  import tssc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_write,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data,
  input  logic         item_accept,
  input  tssc_item_t   item,
  output tssc_result_t result
);

  logic [6:0]  client_address;
  logic [12:0] wait_seconds;
  logic [4:0]  frame_length;

  logic [1:0]  phase_reg, phase_next;
  logic        client_selected, client_selected_next;
  logic [4:0]  byte_count, byte_count_next;
  logic        header_ok, header_ok_next;
  logic [15:0] digit_accumulator, digit_accumulator_next;
  logic [15:0] duration_reg, duration_reg_next;
  logic        wait_armed, wait_armed_next;
  logic [15:0] tick_count, tick_count_next;
  logic [15:0] wake_count, wake_count_next;

  logic        frame_done, command_valid;
  logic [4:0]  frame_len, count_inc;
  logic        is_digit;
  logic [15:0] acc_times_ten;
  logic [16:0] target_raw;
  logic [15:0] target;
  logic [15:0] tick_inc, tick_after, wake_inc, wake_thresh;

  always_ff @(posedge clk) begin
    if (rst) begin
      client_address <= CLIENT_ADDRESS_RST;
      wait_seconds   <= WAIT_SECONDS_RST;
      frame_length   <= FRAME_LENGTH_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_CLIENT_ADDRESS: client_address <= cfg_data[6:0];
        CFG_WAIT_SECONDS:   wait_seconds   <= cfg_data[12:0];
        CFG_FRAME_LENGTH:   frame_length   <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    frame_len     = (frame_length == 5'd0) ? 5'd1 : frame_length;
    count_inc     = byte_count + 5'd1;
    is_digit      = (item.data_byte >= CHAR_0) && (item.data_byte <= CHAR_9);
    acc_times_ten = {digit_accumulator[12:0], 3'b000} + {digit_accumulator[14:0], 1'b0};
    target_raw    = {1'b0, wait_seconds, 3'b000} + {3'b000, wait_seconds, 1'b0};
    target        = target_raw[16] ? COUNT_MAX : target_raw[15:0];
    tick_inc      = (tick_count == COUNT_MAX) ? tick_count : tick_count + 16'd1;
    wake_inc      = (wake_count == COUNT_MAX) ? wake_count : wake_count + 16'd1;
    wake_thresh   = 16'(duration_reg / WAKE_PERIOD_S);
    tick_after    = tick_count;

    phase_next             = phase_reg;
    client_selected_next   = client_selected;
    byte_count_next        = byte_count;
    header_ok_next         = header_ok;
    digit_accumulator_next = digit_accumulator;
    duration_reg_next      = duration_reg;
    wait_armed_next        = wait_armed;
    tick_count_next        = tick_count;
    wake_count_next        = wake_count;
    frame_done             = 1'b0;
    command_valid          = 1'b0;

    unique case (item.opcode)
      OP_ADDR_MATCH: begin
        if (phase_reg != PH_OFF && item.write_direction &&
            item.bus_address == client_address) begin
          client_selected_next = 1'b1;
        end
      end
      OP_RX_BYTE: begin
        if (phase_reg != PH_OFF && client_selected) begin
          if (byte_count == 5'd0) begin
            header_ok_next         = (item.data_byte == CHAR_S);
            digit_accumulator_next = 16'd0;
          end else if (is_digit) begin
            digit_accumulator_next = acc_times_ten + {12'd0, item.data_byte[3:0]};
          end
          if (count_inc >= frame_len) begin
            frame_done      = 1'b1;
            command_valid   = header_ok_next;
            byte_count_next = 5'd0;
            if (header_ok_next) begin
              duration_reg_next = digit_accumulator_next;
              phase_next        = PH_WAIT;
              wait_armed_next   = 1'b0;
              tick_count_next   = 16'd0;
            end else if (phase_reg == PH_WAIT) begin
              // A bad frame cancels the pending shutdown.
              phase_next      = PH_IDLE;
              wait_armed_next = 1'b0;
              tick_count_next = 16'd0;
            end
          end else begin
            byte_count_next = count_inc;
          end
        end
      end
      OP_STOP: begin
        if (phase_reg != PH_OFF) begin
          byte_count_next        = 5'd0;
          header_ok_next         = 1'b0;
          digit_accumulator_next = 16'd0;
        end
      end
      OP_TICK: begin
        if (phase_reg == PH_WAIT) begin
          // The first tick only arms the wait so a partial period is not counted.
          if (wait_armed) begin
            tick_after = tick_inc;
          end else begin
            wait_armed_next = 1'b1;
          end
          if (tick_after >= target) begin
            phase_next      = PH_OFF;
            wait_armed_next = 1'b0;
            tick_count_next = 16'd0;
            wake_count_next = 16'd0;
          end else begin
            tick_count_next = tick_after;
          end
        end
      end
      OP_WD_WAKE: begin
        if (phase_reg == PH_OFF) begin
          if (wake_inc >= wake_thresh) begin
            phase_next      = PH_IDLE;
            wake_count_next = 16'd0;
          end else begin
            wake_count_next = wake_inc;
          end
        end
      end
      OP_PIN_WAKE: begin
        if (phase_reg == PH_OFF) begin
          phase_next = PH_IDLE;
        end
        wake_count_next = 16'd0;
      end
      default: ;
    endcase

    result.regulator_on  = (phase_next != PH_OFF);
    result.phase         = phase_next;
    result.frame_done    = frame_done;
    result.command_valid = command_valid;
    result.off_duration  = duration_reg_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg         <= PH_IDLE;
      client_selected   <= 1'b0;
      byte_count        <= 5'd0;
      header_ok         <= 1'b0;
      digit_accumulator <= 16'd0;
      duration_reg      <= 16'd0;
      wait_armed        <= 1'b0;
      tick_count        <= 16'd0;
      wake_count        <= 16'd0;
    end else if (item_accept) begin
      phase_reg         <= phase_next;
      client_selected   <= client_selected_next;
      byte_count        <= byte_count_next;
      header_ok         <= header_ok_next;
      digit_accumulator <= digit_accumulator_next;
      duration_reg      <= duration_reg_next;
      wait_armed        <= wait_armed_next;
      tick_count        <= tick_count_next;
      wake_count        <= wake_count_next;
    end
  end

endmodule

// ----- sv/tssc_outbuf.sv -----
// Two-entry result buffer: an output register backed by a skid register.
// Depends on tssc_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "timed_supply_shutdown_controller_macros.svh"

module tssc_outbuf
  import tssc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  tssc_result_t push_data,
  output logic         has_room,
  output logic         out_valid,
  input  logic         out_ready,
  output tssc_result_t out_data
);

  logic         head_valid;
  tssc_result_t head_data;
  logic         skid_valid;
  tssc_result_t skid_data;
  logic         pop;

  assign pop       = head_valid && out_ready;
  assign has_room  = !skid_valid;
  assign out_valid = head_valid;
  assign out_data  = head_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      priority if (skid_valid && pop) begin
        head_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else if (push && head_valid && !pop) begin
        skid_valid <= 1'b1;
      end else begin
        head_valid <= push || (head_valid && !pop);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid && pop) begin
      head_data <= skid_data;
    end else if (push && (!head_valid || pop)) begin
      head_data <= push_data;
    end
    if (push && head_valid && !pop) begin
      skid_data <= push_data;
    end
  end

  `TSSC_ASSERT_ALWAYS(a_skid_behind_head, (skid_valid |-> head_valid), "skid without head")
  `TSSC_ASSERT(a_stall_fills_skid, (push && head_valid && !out_ready |=> skid_valid), "lost beat")
  `TSSC_ASSERT(a_skid_drains, (skid_valid && out_ready |=> head_valid && !skid_valid), "skid stuck")

endmodule

// ----- sv/timed_supply_shutdown_controller.sv -----
// Top level of the timed supply shutdown controller.
// Instantiates tssc_core and tssc_outbuf; depends on tssc_pkg.
`timescale 1ns / 1ps

// Channel  Direction  Handshake               Payload
// in       input      in_valid / in_ready     opcode, bus_address, write_direction, data_byte
// out      output     out_valid / out_ready   regulator_on, phase, frame_done,
//                                             command_valid, off_duration
// cfg      input      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// Every input beat is decoded combinationally and produces exactly one result beat,
// so the block sustains one item per clock while the result buffer has room; the
// decode logic in tssc_core is the only stage between the state registers and the result register.
// A two-entry result buffer lets a new beat enter while a result waits; in_ready
// drops only when both entries are full. cfg_ready is always high.
// Synchronous reset restores all state and configuration to its reset values.

module timed_supply_shutdown_controller
  import tssc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Configuration writes.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // Event beats.
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  opcode,
  input  logic [6:0]  bus_address,
  input  logic        write_direction,
  input  logic [7:0]  data_byte,
  // Result beats.
  output logic        out_valid,
  input  logic        out_ready,
  output logic        regulator_on,
  output logic [1:0]  phase,
  output logic        frame_done,
  output logic        command_valid,
  output logic [15:0] off_duration
);

  tssc_item_t   item;
  tssc_result_t next_result;
  tssc_result_t out_data;
  logic         item_accept;
  logic         has_room;

  // Registers are written whenever asked; software must write only while idle (unenforced).
  assign cfg_ready = 1'b1;

  assign in_ready    = has_room;
  assign item_accept = in_valid && has_room;

  assign item = {opcode, bus_address, write_direction, data_byte};

  // The core updates its state on each accepted beat and presents the result
  // of that beat combinationally so the buffer can capture it the same edge.
  tssc_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .item_accept (item_accept),
    .item        (item),
    .result      (next_result)
  );

  tssc_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (item_accept),
    .push_data (next_result),
    .has_room  (has_room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign regulator_on  = out_data.regulator_on;
  assign phase         = out_data.phase;
  assign frame_done    = out_data.frame_done;
  assign command_valid = out_data.command_valid;
  assign off_duration  = out_data.off_duration;

endmodule

// ----- test/tb_timed_supply_shutdown_controller.sv -----
// Self-checking testbench for timed_supply_shutdown_controller: directed and random events,
// checked beat by beat against a built-in model of the shutdown/wake sequence.
// Depends on tssc_pkg and the controller RTL only.
`timescale 1ns / 1ps

module tb_timed_supply_shutdown_controller;
  import tssc_pkg::*;

  // Opcodes outside the defined set; the block must treat them as no-ops.
  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  localparam int RANDOM_EVENTS = 1850;
  localparam int RANDOM_PHASES = 6;
  localparam int TICK_CAP      = 60;
  localparam int TIMEOUT_NS    = 5_000_000;

  // All inputs start at known values; reset is held from time zero.
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_CLIENT_ADDRESS;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  opcode = OP_STOP;
  logic [6:0]  bus_address = '0;
  logic        write_direction = 1'b0;
  logic [7:0]  data_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        regulator_on;
  logic [1:0]  phase;
  logic        frame_done;
  logic        command_valid;
  logic [15:0] off_duration;

  timed_supply_shutdown_controller i_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .opcode         (opcode),
    .bus_address    (bus_address),
    .write_direction(write_direction),
    .data_byte      (data_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .regulator_on   (regulator_on),
    .phase          (phase),
    .frame_done     (frame_done),
    .command_valid  (command_valid),
    .off_duration   (off_duration)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Supply model. This is the testbench's own view of the controller: the
  // configuration it believes is loaded and every piece of state that shapes a
  // result. It starts at the reset values and advances on each accepted beat.
  // ---------------------------------------------------------------------------
  logic [6:0]  own_address = CLIENT_ADDRESS_RST;
  logic [12:0] delay_secs  = WAIT_SECONDS_RST;
  logic [4:0]  frame_bytes = FRAME_LENGTH_RST;

  logic [1:0]  sup_phase     = PH_IDLE;
  logic        host_selected = 1'b0;
  logic [4:0]  rx_count      = '0;
  logic        header_seen   = 1'b0;
  logic [15:0] digit_sum     = '0;
  logic [15:0] off_secs      = '0;
  logic        wait_started  = 1'b0;
  logic [15:0] tick_total    = '0;
  logic [15:0] wake_total    = '0;

  tssc_result_t pending_results[$];

  int error_count     = 0;
  int events_sent     = 0;
  int results_checked = 0;
  int commands_taken  = 0;
  int off_results     = 0;

  // Applies one event to the model and returns the result beat it should cause.
  function automatic tssc_result_t predict_supply(input tssc_item_t ev);
    tssc_result_t r;
    logic [4:0]   len;
    int           target;
    logic         done;
    logic         good;
    done   = 1'b0;
    good   = 1'b0;
    len    = (frame_bytes == 5'd0) ? 5'd1 : frame_bytes;
    target = int'(delay_secs) * 10;
    if (target > int'(COUNT_MAX)) target = int'(COUNT_MAX);
    case (ev.opcode)
      OP_ADDR_MATCH: begin
        // Selection is sticky: nothing on the bus ever deselects the host.
        if (sup_phase != PH_OFF && ev.write_direction && ev.bus_address == own_address)
          host_selected = 1'b1;
      end
      OP_RX_BYTE: begin
        if (sup_phase != PH_OFF && host_selected) begin
          if (rx_count == 5'd0) begin
            header_seen = (ev.data_byte == CHAR_S);
            digit_sum   = '0;
          end else if (ev.data_byte >= CHAR_0 && ev.data_byte <= CHAR_9) begin
            // The product is kept to 16 bits, so long digit strings wrap.
            digit_sum = digit_sum * 16'd10 + {8'd0, ev.data_byte - CHAR_0};
          end
          rx_count = rx_count + 5'd1;
          if (rx_count >= len) begin
            done     = 1'b1;
            good     = header_seen;
            rx_count = '0;
            if (good) begin
              off_secs     = digit_sum;
              sup_phase    = PH_WAIT;
              wait_started = 1'b0;
              tick_total   = '0;
            end else if (sup_phase == PH_WAIT) begin
              // A bad frame cancels the countdown that a good one started.
              sup_phase    = PH_IDLE;
              wait_started = 1'b0;
              tick_total   = '0;
            end
          end
        end
      end
      OP_STOP: begin
        if (sup_phase != PH_OFF) begin
          rx_count    = '0;
          header_seen = 1'b0;
          digit_sum   = '0;
        end
      end
      OP_TICK: begin
        if (sup_phase == PH_WAIT) begin
          // The first tick only arms the wait; later ticks count.
          if (wait_started) begin
            if (tick_total != COUNT_MAX) tick_total = tick_total + 16'd1;
          end else begin
            wait_started = 1'b1;
          end
          if (int'(tick_total) >= target) begin
            sup_phase    = PH_OFF;
            wait_started = 1'b0;
            tick_total   = '0;
            wake_total   = '0;
          end
        end
      end
      OP_WD_WAKE: begin
        if (sup_phase == PH_OFF) begin
          if (wake_total != COUNT_MAX) wake_total = wake_total + 16'd1;
          if (int'(wake_total) >= int'(off_secs) / int'(WAKE_PERIOD_S)) begin
            sup_phase  = PH_IDLE;
            wake_total = '0;
          end
        end
      end
      OP_PIN_WAKE: begin
        // A pin wake restores the supply but leaves a pending wait running.
        if (sup_phase == PH_OFF) sup_phase = PH_IDLE;
        wake_total = '0;
      end
      default: ;
    endcase
    r.regulator_on  = (sup_phase != PH_OFF);
    r.phase         = sup_phase;
    r.frame_done    = done;
    r.command_valid = good;
    r.off_duration  = off_secs;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Scoreboard. Everything is sampled at the rising edge, so the values seen
  // are the ones that were stable through the cycle. Configuration writes and
  // accepted events update the model first; a result accepted on the same edge
  // is then compared with the oldest outstanding prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    tssc_item_t   ev;
    tssc_result_t want;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_CLIENT_ADDRESS: own_address = cfg_data[6:0];
          CFG_WAIT_SECONDS:   delay_secs  = cfg_data[12:0];
          CFG_FRAME_LENGTH:   frame_bytes = cfg_data[4:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        ev.opcode          = opcode;
        ev.bus_address     = bus_address;
        ev.write_direction = write_direction;
        ev.data_byte       = data_byte;
        pending_results.push_back(predict_supply(ev));
      end
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("result beat arrived with no prediction outstanding");
          error_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("regulator_on", 16'(want.regulator_on), 16'(regulator_on));
          check_field("phase", 16'(want.phase), 16'(phase));
          check_field("frame_done", 16'(want.frame_done), 16'(frame_done));
          check_field("command_valid", 16'(want.command_valid), 16'(command_valid));
          check_field("off_duration", want.off_duration, off_duration);
          results_checked++;
          if (want.command_valid) commands_taken++;
          if (!want.regulator_on) off_results++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result-side back-pressure. The sink switches at random between
  // always ready, light random stalls, and long runs of ready and not ready.
  // ---------------------------------------------------------------------------
  int sink_mode = 0;
  int sink_mode_left = 0;
  int sink_run_left = 0;

  always @(posedge clk) begin
    if (sink_mode_left == 0) begin
      sink_mode      = $urandom_range(0, 2);
      sink_mode_left = $urandom_range(30, 200);
    end else begin
      sink_mode_left--;
    end
    case (sink_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      default: begin
        if (sink_run_left == 0) begin
          sink_run_left = $urandom_range(1, 12);
          out_ready <= ~out_ready;
        end else begin
          sink_run_left--;
        end
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Stimulus side. The sender works in bursts: inside a burst beats follow
  // back to back, between bursts in_valid drops for a random number of cycles.
  // Each signal gets at most one nonblocking update per edge, so in_valid stays
  // high across consecutive beats of a burst.
  // ---------------------------------------------------------------------------
  int burst_left = 0;

  // Configuration as the stimulus knows it; the model keeps its own copy.
  logic [6:0]  cur_addr = CLIENT_ADDRESS_RST;
  logic [12:0] cur_wait = WAIT_SECONDS_RST;
  logic [4:0]  cur_flen = FRAME_LENGTH_RST;

  task automatic send_event(input logic [2:0] op, input logic [6:0] addr,
                            input logic wr, input logic [7:0] data);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 10);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 60);
    end
    in_valid        <= 1'b1;
    opcode          <= op;
    bus_address     <= addr;
    write_direction <= wr;
    data_byte       <= data;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    if (op <= OP_PIN_WAKE) events_sent++;
  endtask

  // Fields that the opcode does not use carry random values.
  task automatic send_op(input logic [2:0] op);
    send_event(op, 7'($urandom), 1'($urandom), 8'($urandom));
  endtask

  task automatic send_byte(input logic [7:0] data);
    send_event(OP_RX_BYTE, 7'($urandom), 1'($urandom), data);
  endtask

  // Lets the block run dry: stops sending and waits until every predicted
  // result has been taken, then gives the result buffer time to settle.
  // The first edge makes sure the prediction for the last beat is queued.
  task automatic drain();
    in_valid  <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // All three registers go out back to back with cfg_valid held high.
  task automatic write_regs(input logic [6:0] addr, input logic [12:0] secs,
                            input logic [4:0] len);
    logic [1:0]  idx[3];
    logic [15:0] val[3];
    idx[0] = CFG_CLIENT_ADDRESS;  val[0] = 16'(addr);
    idx[1] = CFG_WAIT_SECONDS;    val[1] = 16'(secs);
    idx[2] = CFG_FRAME_LENGTH;    val[2] = 16'(len);
    for (int k = 0; k < 3; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    cur_addr = addr;
    cur_wait = secs;
    cur_flen = len;
  endtask

  // One frame of cur_flen bytes. The header is 'S' for a command; the body is
  // mostly digits with other bytes mixed in. Now and then a stop breaks the
  // frame partway, which leaves the remaining bytes to start a new one.
  task automatic send_frame(input bit good_header);
    logic [7:0] b;
    for (int k = 0; k < int'(cur_flen); k++) begin
      if (k == 0) b = good_header ? CHAR_S : 8'($urandom);
      else if ($urandom_range(0, 9) < 7) b = CHAR_0 + 8'($urandom_range(0, 9));
      else b = 8'($urandom);
      if ($urandom_range(0, 29) == 0) send_op(OP_STOP);
      send_byte(b);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Directed tests. They run with address 127, no wait and three-byte frames,
  // so a command shuts the supply down on its first tick.
  // ---------------------------------------------------------------------------

  // Bytes are ignored until a host write to our own address selects us; a
  // read or a foreign address does not select.
  task automatic test_bus_select();
    send_byte(CHAR_S);
    send_event(OP_ADDR_MATCH, 7'h7F, 1'b0, 8'h00);
    send_event(OP_ADDR_MATCH, 7'h00, 1'b1, 8'hFF);
    send_event(OP_ADDR_MATCH, 7'h7F, 1'b1, 8'h00);
  endtask

  // Bad header, a stop in mid-frame, a good command, a bad frame cancelling
  // the wait, then the good command again to leave a wait pending.
  task automatic test_frame_decode();
    send_byte(8'h00);
    send_byte(CHAR_0 + 8'd7);
    send_byte(8'hFF);
    send_byte(CHAR_S);
    send_byte(CHAR_0 + 8'd9);
    send_op(OP_STOP);
    send_byte(CHAR_S);
    send_byte(CHAR_0 + 8'd4);
    send_byte(CHAR_0);
    send_byte(8'h51);
    send_byte(CHAR_0 + 8'd1);
    send_byte(CHAR_0 + 8'd1);
    send_byte(CHAR_S);
    send_byte(CHAR_0 + 8'd4);
    send_byte(CHAR_0);
  endtask

  // Tick turns the supply off; bus events are then ignored, a watchdog wake
  // counts, and a pin wake brings the supply back at once.
  task automatic test_shutdown_and_wake();
    send_op(OP_TICK);
    send_byte(CHAR_S);
    send_op(OP_STOP);
    send_op(OP_WD_WAKE);
    send_op(OP_PIN_WAKE);
  endtask

  task automatic test_spare_opcodes();
    send_event(OP_SPARE_LO, 7'h7F, 1'b1, 8'hFF);
    send_event(OP_SPARE_HI, 7'h00, 1'b0, 8'h00);
  endtask

  // ---------------------------------------------------------------------------
  // Random traffic. Each phase loads a new configuration while the block is
  // idle, then mixes complete command sessions (select, frame, stop, ticks up
  // to shutdown, watchdog or pin wakes) with bursts of unrelated events.
  // ---------------------------------------------------------------------------
  task automatic run_random_phase(input int budget);
    int stop_at;
    int n;
    stop_at = events_sent + budget;
    while (events_sent < stop_at) begin
      if ($urandom_range(0, 9) < 7) begin
        if ($urandom_range(0, 1) != 0) send_op(OP_STOP);
        case ($urandom_range(0, 9))
          0: send_event(OP_ADDR_MATCH, 7'($urandom), 1'($urandom), 8'($urandom));
          1: send_event(OP_ADDR_MATCH, cur_addr, 1'b0, 8'($urandom));
          default: send_event(OP_ADDR_MATCH, cur_addr, 1'b1, 8'($urandom));
        endcase
        send_frame($urandom_range(0, 9) != 0);
        send_op(OP_STOP);
        // Enough ticks to reach shutdown where the delay allows it, sometimes
        // fewer; a pin wake or a bad frame may land in the middle of the wait.
        n = int'(cur_wait) * 10 + 2;
        if (n > TICK_CAP) n = TICK_CAP;
        if ($urandom_range(0, 3) == 0) n = $urandom_range(0, n);
        repeat (n) begin
          send_op(OP_TICK);
          if ($urandom_range(0, 19) == 0) send_op(OP_PIN_WAKE);
          if ($urandom_range(0, 39) == 0) send_frame(1'b0);
        end
        n = $urandom_range(0, 40);
        repeat (n) send_op(OP_WD_WAKE);
        if ($urandom_range(0, 1) != 0) send_op(OP_PIN_WAKE);
      end else begin
        n = $urandom_range(1, 8);
        repeat (n) begin
          if ($urandom_range(0, 31) == 0) send_op(3'($urandom_range(6, 7)));
          else send_op(3'($urandom_range(0, 5)));
        end
      end
    end
  endtask

  task automatic test_random_traffic();
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain();
      case (p)
        0: write_regs(7'h00, 13'd0, 5'd1);
        1: write_regs(7'h7F, 13'd1, 5'd16);
        2: write_regs(7'($urandom), 13'd2, 5'($urandom_range(2, 6)));
        3: write_regs(7'($urandom), 13'd6553, 5'($urandom_range(1, 4)));
        default: write_regs(7'($urandom), 13'($urandom_range(0, 5)),
                            5'($urandom_range(1, 16)));
      endcase
      run_random_phase(RANDOM_EVENTS / RANDOM_PHASES);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    write_regs(7'h7F, 13'd0, 5'd3);
    test_bus_select();
    test_frame_decode();
    test_shutdown_and_wake();
    test_spare_opcodes();
    test_random_traffic();
    drain();
    $display("Covered %0d events and %0d result beats: %0d accepted commands,",
             events_sent, results_checked, commands_taken);
    $display("%0d results with the regulator off, %0d mismatches.", off_results, error_count);
    if (error_count == 0) begin
      $display("[timed_supply_shutdown_controller] OK");
    end else begin
      $display("[timed_supply_shutdown_controller] ERROR");
    end
    $finish;
  end

  // Safety net: a hung handshake ends the run as a failure.
  initial begin
    #(TIMEOUT_NS);
    $display("[timed_supply_shutdown_controller] ERROR");
    $finish;
  end

endmodule
